[rtl/core/hsr_pkg.sv]
// ----------------------------------------------------------------------------
// hsr_pkg: shared constants for the Heron square root block
// Fixed-point formats, divider geometry and iteration limit defaults.
// ----------------------------------------------------------------------------
package hsr_pkg;

  // Radicand width and fractional bits of the Q format
  localparam int unsigned RadicandBits = 32;
  localparam int unsigned FractionBits = 16;

  // Divider works on the radicand scaled by 2^(2F); estimate has the same width
  localparam int unsigned TotalBits = RadicandBits + 2 * FractionBits;
  localparam int unsigned CountBits = $clog2(TotalBits);

  // Result and iteration count widths
  localparam int unsigned RootBits = 32;
  localparam int unsigned IterBits = 10;

  // Iteration limit after reset
  localparam logic [IterBits-1:0] MaxIterReset = IterBits'(998);

endpackage

[rtl/core/heron_square_root.sv]
// ----------------------------------------------------------------------------
// heron_square_root: integer square root in Q16.16 by Heron's iteration
// Shared restoring divider under a small sequencer; one radicand at a time.
// ----------------------------------------------------------------------------
// Takes an unsigned 32-bit radicand and returns its square root in unsigned
// Q16.16, starting from 1.0 and repeating x = (x + n/x)/2 until the estimate
// stops falling or max_iterations steps are spent. Each step runs one
// 64-bit restoring division, one quotient bit per cycle on the shared
// subtractor, followed by a sum state (StAdd) and a compare state (StCheck);
// a zero radicand or a zero limit goes from idle straight to the finish
// state. The input is taken only while the sequencer is idle; a finished
// result waits in the output register, so the next radicand may be taken
// before the result is read. max_iterations is written through cfg_we_i /
// cfg_wdata_i; the user must write it only while idle, as the block does
// not enforce this.
module heron_square_root
  import hsr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [IterBits-1:0]     cfg_wdata_i,
  // input item
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RadicandBits-1:0] radicand_i,
  // result item
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [RootBits-1:0]     root_o,
  output logic [IterBits-1:0]     iterations_used_o,
  output logic                    converged_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StDiv    = 5'b00010,
    StAdd    = 5'b00100,
    StCheck  = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [IterBits-1:0]   max_iter_q;
  logic [TotalBits-1:0]  n_q;         // radicand, kept for every step
  logic [TotalBits-1:0]  dvd_q;       // scaled radicand, shifted out MSB first
  logic [TotalBits-1:0]  x_q, x_d;    // current estimate
  logic [TotalBits-1:0]  nx_q, nx_d;  // next estimate
  logic [TotalBits-1:0]  rem_q, rem_d;
  logic [TotalBits-1:0]  quo_q, quo_d;
  logic                  sat_q, sat_d;
  logic [CountBits-1:0]  cnt_q, cnt_d;
  logic [IterBits-1:0]   iter_q, iter_d;
  logic                  conv_q, conv_d;
  logic                  start_div;
  logic                  load_dvd;

  logic                  out_valid_q;
  logic [RootBits-1:0]   root_q;
  logic [IterBits-1:0]   used_q;
  logic                  conv_out_q;

  logic                  in_acc;
  logic                  out_load;
  logic [TotalBits-1:0]  rem_sh;
  logic [TotalBits:0]    trial;
  logic                  trial_ok;
  logic [TotalBits-1:0]  q_eff;
  logic [IterBits-1:0]   iter_inc;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == StFinish) && (!out_valid_q || out_ready_i);

  // Divider step: shift in the next dividend bit and try the subtraction
  assign rem_sh   = {rem_q[TotalBits-2:0], dvd_q[TotalBits-1]};
  assign trial    = {rem_q[TotalBits-1], rem_sh} - {1'b0, x_q};
  assign trial_ok = !trial[TotalBits];

  // Saturate an overflowed quotient
  assign q_eff    = sat_q ? {TotalBits{1'b1}} : quo_q;
  assign iter_inc = iter_q + IterBits'(1);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    nx_d      = nx_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    sat_d     = sat_q;
    cnt_d     = cnt_q;
    iter_d    = iter_q;
    conv_d    = conv_q;
    start_div = 1'b0;
    load_dvd  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          x_d    = TotalBits'(1) << FractionBits;
          iter_d = '0;
          conv_d = 1'b0;
          if (radicand_i == '0) begin
            x_d     = '0;
            conv_d  = 1'b1;
            state_d = StFinish;
          end else if (max_iter_q == '0) begin
            state_d = StFinish;
          end else begin
            start_div = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        sat_d = sat_q | quo_q[TotalBits-1];
        if (trial_ok) begin
          rem_d = trial[TotalBits-1:0];
          quo_d = {quo_q[TotalBits-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[TotalBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - CountBits'(1);
        if (cnt_q == '0) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        nx_d    = (x_q >> 1) + (q_eff >> 1) + TotalBits'(x_q[0] & q_eff[0]);
        iter_d  = iter_inc;
        state_d = StCheck;
      end
      StCheck: begin
        if ((nx_q == x_q) || ((iter_q >= IterBits'(2)) && (nx_q > x_q))) begin
          conv_d  = 1'b1;
          state_d = StFinish;
        end else begin
          x_d = nx_q;
          if (iter_q == max_iter_q) begin
            state_d = StFinish;
          end else begin
            start_div = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StFinish: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // Prime the divider for a new step
    if (start_div) begin
      load_dvd = 1'b1;
      rem_d    = '0;
      quo_d    = '0;
      sat_d    = (x_d == '0);
      cnt_d    = CountBits'(TotalBits - 1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_iter_q  <= MaxIterReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_iter_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    nx_q   <= nx_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    sat_q  <= sat_d;
    cnt_q  <= cnt_d;
    iter_q <= iter_d;
    conv_q <= conv_d;
    if (in_acc) begin
      n_q <= TotalBits'(radicand_i);
    end
    if (load_dvd) begin
      dvd_q <= (in_acc ? TotalBits'(radicand_i) : n_q) << (2 * FractionBits);
    end else if (state_q == StDiv) begin
      dvd_q <= dvd_q << 1;
    end
    // Hold the result until taken
    if (out_load) begin
      root_q     <= x_q[RootBits-1:0];
      used_q     <= iter_q;
      conv_out_q <= conv_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign root_o            = root_q;
  assign iterations_used_o = used_q;
  assign converged_o       = conv_out_q;

endmodule

[sim/heron_square_root_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heron_square_root_tb: self-checking bench for the Heron square root block
// Feeds radicands over a valid/ready channel under several iteration limits,
// predicts each Q16.16 root, step count and convergence flag in the bench,
// and compares every returned item field by field against the oldest
// outstanding prediction. Both sides idle in random bursts; one long stall
// on the result side backs the block up against its input.
// ----------------------------------------------------------------------------
module heron_square_root_tb;
  import hsr_pkg::*;

  // One predicted or observed result item
  typedef struct packed {
    logic [RootBits-1:0] root;
    logic [IterBits-1:0] steps;
    logic                converged;
  } root_result_t;

  // Predict results, hold them in order and compare against the block
  class heron_scoreboard;
    logic [IterBits-1:0] iter_limit;
    root_result_t        pending_roots[$];
    int unsigned         errors;
    int unsigned         results_checked;
    int unsigned         radicands_noted;
    int unsigned         limit_stops;
    int unsigned         zero_radicands;

    function new();
      iter_limit      = MaxIterReset;
      errors          = 0;
      results_checked = 0;
      radicands_noted = 0;
      limit_stops     = 0;
      zero_radicands  = 0;
    endfunction

    // Run Heron's iteration in Q16.16 from an estimate of 1.0
    function root_result_t heron_root(input logic [RadicandBits-1:0] n);
      root_result_t          r;
      logic [TotalBits-1:0]  scaled;
      logic [TotalBits-1:0]  est;
      logic [TotalBits-1:0]  quot;
      logic [TotalBits-1:0]  next_est;
      logic [TotalBits:0]    total;
      int unsigned           step;
      r = '0;
      if (n == '0) begin
        r.converged = 1'b1;
        return r;
      end
      scaled = TotalBits'(n) << (2 * FractionBits);
      est    = TotalBits'(1) << FractionBits;
      for (step = 1; step <= iter_limit; step++) begin
        quot     = (est == '0) ? '1 : scaled / est;
        total    = {1'b0, est} + {1'b0, quot};
        next_est = total[TotalBits:1];
        r.steps  = IterBits'(step);
        // stop once the estimate no longer falls
        if (next_est == est || (step >= 2 && next_est > est)) begin
          r.converged = 1'b1;
          break;
        end
        est = next_est;
      end
      r.root = est[RootBits-1:0];
      return r;
    endfunction

    function void note_radicand(input logic [RadicandBits-1:0] n);
      pending_roots.push_back(heron_root(n));
      radicands_noted++;
      if (n == '0) zero_radicands++;
    endfunction

    function void report(input string what);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $time, what);
    endfunction

    function void check_root(input logic [RootBits-1:0] root,
                             input logic [IterBits-1:0] steps,
                             input logic                converged);
      root_result_t want;
      if (pending_roots.size() == 0) begin
        report($sformatf("unexpected item: root %h steps %0d converged %b",
                         root, steps, converged));
        return;
      end
      want = pending_roots.pop_front();
      results_checked++;
      if (!want.converged) limit_stops++;
      if (root !== want.root)
        report($sformatf("item %0d root: want %h got %h",
                         results_checked, want.root, root));
      if (steps !== want.steps)
        report($sformatf("item %0d steps: want %0d got %0d",
                         results_checked, want.steps, steps));
      if (converged !== want.converged)
        report($sformatf("item %0d converged: want %b got %b",
                         results_checked, want.converged, converged));
    endfunction
  endclass

  localparam int unsigned HoldoffCycles = 4000;
  localparam int unsigned HoldoffAfter  = 60;
  localparam int unsigned PhaseItems    = 145;
  localparam int unsigned PhaseCount    = 5;

  // Corner radicands: zero, one, small, powers of two, squares, top of range
  localparam logic [RadicandBits-1:0] CornerRadicands [16] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'h0000_0004, 32'h0000_0005, 32'h0000_0090, 32'h0000_FFFF,
    32'h0001_0000, 32'h000F_4240, 32'h4000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hFFFE_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    cfg_we_i          = 1'b0;
  logic [IterBits-1:0]     cfg_wdata_i       = '0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_ready_o;
  logic [RadicandBits-1:0] radicand_i        = '0;
  logic                    out_valid_o;
  logic                    out_ready_i       = 1'b0;
  logic [RootBits-1:0]     root_o;
  logic [IterBits-1:0]     iterations_used_o;
  logic                    converged_o;

  heron_scoreboard board;
  bit              idle_enabled   = 1'b1;
  int unsigned     limits_written = 0;

  heron_square_root DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .radicand_i        (radicand_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .root_o            (root_o),
    .iterations_used_o (iterations_used_o),
    .converged_o       (converged_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offer one radicand and hold it until taken; idle for a burst now and then
  task automatic send_radicand(input logic [RadicandBits-1:0] value);
    radicand_i <= value;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_radicand(value);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every outstanding item to come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending_roots.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_step_limit(input logic [IterBits-1:0] limit);
    cfg_wdata_i <= limit;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.iter_limit = limit;
    limits_written++;
  endtask

  // Random radicand of random bit width, with zeros, full scale and squares mixed in
  function automatic logic [RadicandBits-1:0] pick_radicand();
    logic [RadicandBits-1:0] value;
    logic [RadicandBits-1:0] side;
    int unsigned             width;
    width = $urandom_range(1, RadicandBits);
    value = $urandom;
    side  = $urandom_range(1, 65535);
    case ($urandom_range(0, 19))
      0:       value = '0;
      1:       value = '1;
      2:       value = side * side;
      default: value = value >> (RadicandBits - width);
    endcase
    return value;
  endfunction

  // Accept results, idle in bursts, and stall once for a long stretch
  initial begin : result_sink
    int unsigned stall_left;
    bit          holdoff_done;
    stall_left   = 0;
    holdoff_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        board.check_root(root_o, iterations_used_o, converged_o);
      if (!holdoff_done && board.results_checked >= HoldoffAfter) begin
        holdoff_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldoffCycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_enabled && stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = 0;
        out_ready_i <= 1'b1;
      end
    end
  end

  // Directed corners, then random phases under changing step limits
  initial begin : stimulus
    logic [IterBits-1:0] limit;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners under the reset limit
    foreach (CornerRadicands[k]) send_radicand(CornerRadicands[k]);
    drain_results();

    // zero limit: no step taken, zero radicand still short-circuits
    write_step_limit('0);
    send_radicand(32'h0000_0000);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0000_0007);
    drain_results();

    // single step: only exact roots of one converge
    write_step_limit(IterBits'(1));
    send_radicand(32'h0000_0001);
    send_radicand(32'h0000_0002);
    send_radicand(32'hFFFF_FFFF);
    drain_results();

    write_step_limit('1);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h1234_5678);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      case (phase)
        0:       limit = '1;
        1:       limit = IterBits'($urandom_range(2, 16));
        2:       limit = IterBits'($urandom_range(1, 1023));
        3:       limit = MaxIterReset;
        default: limit = '1;
      endcase
      // run the last phase flat out
      if (phase == PhaseCount - 1) idle_enabled = 1'b0;
      write_step_limit(limit);
      repeat (PhaseItems) send_radicand(pick_radicand());
    end

    drain_results();
    repeat (2000) @(posedge clk_i);

    $display("Checked %0d of %0d radicands over %0d step-limit writes.",
             board.results_checked, board.radicands_noted, limits_written);
    $display("%0d stopped at the step limit, %0d zero radicands, %0d errors.",
             board.limit_stops, board.zero_radicands, board.errors);
    if (board.errors == 0 && board.pending_roots.size() == 0) begin
      $display("heron_square_root regression: pass");
    end else begin
      $display("heron_square_root regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #60_000_000;
    $display("heron_square_root regression: fail");
    $finish;
  end

endmodule
